/* rtl/core/mcbs_pkg.sv */
// ----------------------------------------------------------------------------
// Magnet code bin selector package
// Register indexes, field widths and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package mcbs_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CountW    = 4;
  localparam int unsigned BinW      = 2;
  localparam int unsigned NumSensor = 2;

  // An item ends early once this many magnets have been counted.
  localparam logic [CountW-1:0] CodeMax  = 4'd4;
  localparam logic [CountW-1:0] CountMax = 4'd15;

  localparam logic [CfgDataW-1:0] DebounceReset = 16'd100;
  localparam logic [CfgDataW-1:0] WindowReset   = 16'd70;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_WINDOW    = 3'd1,
    REG_BIN_ONE   = 3'd2,
    REG_BIN_TWO   = 3'd3,
    REG_BIN_THREE = 3'd4,
    REG_BIN_FOUR  = 3'd5
  } cfg_reg_e;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [BinW-1:0]     bin_t;

endpackage

/* rtl/core/magnet_code_bin_selector.sv */
// ----------------------------------------------------------------------------
// Magnet code bin selector
// Debounces two magnet sensors, counts magnets for one item until the window
// or limit ends it after the feeder home switch, and maps the count to a bin.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: action; tdata: sensor_a, sensor_b, feeder_home
//  m_axis    out        tlast: item_done; tdata: magnet_count, chosen_bin,
//                       scanning
//  cfg       in         register index and 16-bit write data
//
//  Every accepted input beat yields exactly one output beat in the next cycle.
//  One input beat is taken per cycle; the state update and the result are
//  computed in a single pass between the state registers and the output
//  register. The input stalls only while the output register is full and
//  the sink holds tready low. Reset clears the item state and the output
//  valid flag, loads the register defaults and leaves the block ready.
//
module magnet_code_bin_selector #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [2:0] sensor_a, sensor_b, feeder_home; [7:3] zero
  input  logic [7:0]               s_axis_tdata,
  // [0] action
  input  logic                     s_axis_tuser,

  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [3:0] magnet_count, [5:4] chosen_bin, [6] scanning, [7] zero
  output logic [7:0]               m_axis_tdata,
  output logic                     m_axis_tlast,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  mcbs_pkg::cfg_idx_t       cfg_index_i,
  input  mcbs_pkg::cfg_data_t      cfg_data_i
);

  import mcbs_pkg::*;

  localparam int unsigned CmpW = (TIMER_WIDTH > CfgDataW) ? TIMER_WIDTH : CfgDataW;

  // Configuration registers
  cfg_data_t debounce_q, window_q;
  bin_t      bin_one_q, bin_two_q, bin_three_q, bin_four_q;

  // Item state
  logic                   latch_q [NumSensor];
  logic [TIMER_WIDTH-1:0] hold_q  [NumSensor];
  logic                   latch_d [NumSensor];
  logic [TIMER_WIDTH-1:0] hold_d  [NumSensor];
  logic                   hit     [NumSensor];
  logic                   level   [NumSensor];
  count_t                 count_q, count_d;
  logic                   scan_q, scan_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic                   phase2_q, phase2_d;
  logic                   finished_q, finished_d;
  logic                   done_d;
  bin_t                   bin_d;

  // Output register
  logic   out_valid_q;
  logic   out_done_q;
  count_t out_count_q;
  bin_t   out_bin_q;
  logic   out_scan_q;

  logic s_hs, m_hs, action;

  assign action        = s_axis_tuser;
  assign level[0]      = s_axis_tdata[0];
  assign level[1]      = s_axis_tdata[1];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign m_hs          = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceReset;
      window_q    <= WindowReset;
      bin_one_q   <= '0;
      bin_two_q   <= '0;
      bin_three_q <= '0;
      bin_four_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        REG_WINDOW:    window_q    <= cfg_data_i;
        REG_BIN_ONE:   bin_one_q   <= cfg_data_i[BinW-1:0];
        REG_BIN_TWO:   bin_two_q   <= cfg_data_i[BinW-1:0];
        REG_BIN_THREE: bin_three_q <= cfg_data_i[BinW-1:0];
        REG_BIN_FOUR:  bin_four_q  <= cfg_data_i[BinW-1:0];
        default: ;
      endcase
    end
  end

  // Debouncers: a high level counts up, and a count is taken once the hold
  // reaches the setting while unlatched. A low level re-arms a hold that reached it.
  always_comb begin
    logic [TIMER_WIDTH-1:0] inc;
    for (int s = 0; s < NumSensor; s++) begin
      inc        = (hold_q[s] == '1) ? hold_q[s] : hold_q[s] + 1'b1;
      latch_d[s] = latch_q[s];
      hold_d[s]  = hold_q[s];
      hit[s]     = 1'b0;
      if (level[s]) begin
        hold_d[s] = inc;
        if (!latch_q[s] && (CmpW'(inc) >= CmpW'(debounce_q))) begin
          latch_d[s] = 1'b1;
          hold_d[s]  = '0;
          hit[s]     = 1'b1;
        end
      end else if (CmpW'(hold_q[s]) >= CmpW'(debounce_q)) begin
        latch_d[s] = 1'b0;
        hold_d[s]  = '0;
      end
    end
  end

  always_comb begin
    logic [CountW:0] sum;
    sum        = {1'b0, count_q} + (CountW+1)'(hit[0]) + (CountW+1)'(hit[1]);
    count_d    = count_q;
    scan_d     = scan_q;
    timer_d    = timer_q;
    phase2_d   = phase2_q;
    finished_d = finished_q;
    done_d     = 1'b0;
    if (action) begin
      count_d    = '0;
      scan_d     = 1'b0;
      timer_d    = '0;
      phase2_d   = 1'b0;
      finished_d = 1'b0;
    end else if (!finished_q) begin
      if (scan_q && timer_q != '1) begin
        timer_d = timer_q + 1'b1;
      end
      if (level[0] || level[1]) begin
        scan_d = 1'b1;
      end
      count_d = (sum > (CountW+1)'(CountMax)) ? CountMax : sum[CountW-1:0];
      if (!phase2_q) begin
        phase2_d = s_axis_tdata[2];
      end else if ((CmpW'(timer_d) >= CmpW'(window_q)) || (count_d >= CodeMax)) begin
        finished_d = 1'b1;
        done_d     = 1'b1;
      end
    end
  end

  always_comb begin
    bin_d = '0;
    if (finished_d) begin
      case (count_d)
        4'd1:    bin_d = bin_one_q;
        4'd2:    bin_d = bin_two_q;
        4'd3:    bin_d = bin_three_q;
        4'd4:    bin_d = bin_four_q;
        default: bin_d = '0;
      endcase
    end
  end

  // Debouncer state is kept across a start beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSensor; s++) begin
        latch_q[s] <= 1'b0;
        hold_q[s]  <= '0;
      end
      count_q    <= '0;
      scan_q     <= 1'b0;
      timer_q    <= '0;
      phase2_q   <= 1'b0;
      finished_q <= 1'b0;
    end else if (s_hs) begin
      if (!action && !finished_q) begin
        for (int s = 0; s < NumSensor; s++) begin
          latch_q[s] <= latch_d[s];
          hold_q[s]  <= hold_d[s];
        end
      end
      count_q    <= count_d;
      scan_q     <= scan_d;
      timer_q    <= timer_d;
      phase2_q   <= phase2_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_hs) begin
      out_valid_q <= 1'b1;
    end else if (m_hs) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      out_done_q  <= done_d;
      out_count_q <= count_d;
      out_bin_q   <= bin_d;
      out_scan_q  <= scan_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_done_q;
  assign m_axis_tdata  = {1'b0, out_scan_q, out_bin_q, out_count_q};

  // A start beat always yields an all-zero result.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && s_axis_tuser |=> m_axis_tvalid && out_count_q == '0 && !out_scan_q
                             && !out_done_q && out_bin_q == '0)
    else $error("start beat did not clear the result");

  // A closing beat can only be shown while the item is finished.
  a_done_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> finished_q)
    else $error("item_done shown while item not finished");

  // Once finished, ticks leave the count and the finished flag alone.
  a_finished_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && !s_axis_tuser && finished_q |=> finished_q && $stable(count_q))
    else $error("state changed after item finished");

  // Item state moves only on an accepted beat.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_hs |=> $stable(count_q) && $stable(timer_q))
    else $error("item state changed without an input beat");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Magnet code bin selector testbench
// Drives tick beats with debounce pulses, feeder home and start actions
// through the stream input. A scoreboard predicts every output beat and
// compares it field by field. Several register settings are loaded between
// phases, and random idling on both sides is mixed with a long receiver
// hold-off and a long run with one sensor held high.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcbs_pkg::*;

  localparam int unsigned TimerW        = 16;
  localparam int          RandomBeats   = 1100;
  localparam int          HoldOffCycles = 300;
  localparam int          SatTicks      = 60;

  typedef logic [TimerW-1:0] ticks_t;

  typedef struct packed {
    logic   done;
    count_t count;
    bin_t   bin;
    logic   scanning;
  } tally_t;

  typedef struct {
    cfg_data_t debounce;
    cfg_data_t window;
    cfg_data_t bin_word [4];
  } setting_t;

  // Tracks the selector state and holds the results still owed by the block.
  class tally_board;
    cfg_data_t debounce = DebounceReset;
    cfg_data_t window   = WindowReset;
    bin_t      bin_map [4];
    bit        latched [NumSensor];
    ticks_t    hold [NumSensor];
    count_t    count;
    bit        scan;
    ticks_t    timer;
    bit        second;
    bit        finished;
    tally_t    expected [$];
    int        n_in;
    int        n_out;
    int        n_closed;
    int        errors;

    function new();
      foreach (bin_map[i]) bin_map[i] = '0;
      foreach (hold[i]) begin
        hold[i]    = '0;
        latched[i] = 1'b0;
      end
      count    = '0;
      scan     = 1'b0;
      timer    = '0;
      second   = 1'b0;
      finished = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, cfg_data_t v);
      case (idx)
        REG_DEBOUNCE:  debounce   = v;
        REG_WINDOW:    window     = v;
        REG_BIN_ONE:   bin_map[0] = v[BinW-1:0];
        REG_BIN_TWO:   bin_map[1] = v[BinW-1:0];
        REG_BIN_THREE: bin_map[2] = v[BinW-1:0];
        REG_BIN_FOUR:  bin_map[3] = v[BinW-1:0];
        default: ;
      endcase
    endfunction

    function void sense(int s, bit level);
      if (level) begin
        scan = 1'b1;
        if (hold[s] != '1) hold[s]++;
        if (!latched[s] && hold[s] >= debounce) begin
          latched[s] = 1'b1;
          if (count != CountMax) count++;
          hold[s] = '0;
        end
      end else if (hold[s] >= debounce) begin
        latched[s] = 1'b0;
        hold[s]    = '0;
      end
    endfunction

    function bin_t bin_of(count_t c);
      if (c >= 1 && c <= CodeMax) return bin_map[c-1];
      return '0;
    endfunction

    function void note_tick(bit act, bit sa, bit sb_lvl, bit home);
      tally_t t;
      bit done;
      done = 1'b0;
      n_in++;
      if (act) begin
        count    = '0;
        timer    = '0;
        second   = 1'b0;
        finished = 1'b0;
        scan     = 1'b0;
      end else if (!finished) begin
        if (scan && timer != '1) timer++;
        sense(0, sa);
        sense(1, sb_lvl);
        // The tick that sees the feeder switch only opens the second phase.
        if (!second) begin
          if (home) second = 1'b1;
        end else if (timer >= window || count >= CodeMax) begin
          finished = 1'b1;
          done     = 1'b1;
        end
      end
      t.done     = done;
      t.count    = count;
      t.bin      = finished ? bin_of(count) : '0;
      t.scanning = scan;
      expected.push_back(t);
    endfunction

    function void check_tally(logic done, count_t count_o, bin_t bin_o, logic scan_o);
      tally_t t;
      if (expected.size() == 0) begin
        $error("result beat with no expected result: magnet_count %0d", count_o);
        errors++;
        return;
      end
      t = expected.pop_front();
      n_out++;
      if (t.done) n_closed++;
      if (t.done !== done) begin
        $error("item_done mismatch: expected %0d, actual %0d", t.done, done);
        errors++;
      end
      if (t.count !== count_o) begin
        $error("magnet_count mismatch: expected %0d, actual %0d", t.count, count_o);
        errors++;
      end
      if (t.bin !== bin_o) begin
        $error("chosen_bin mismatch: expected %0d, actual %0d", t.bin, bin_o);
        errors++;
      end
      if (t.scanning !== scan_o) begin
        $error("scanning mismatch: expected %0d, actual %0d", t.scanning, scan_o);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  cfg_idx_t   cfg_index_i;
  cfg_data_t  cfg_data_i;

  tally_board board;
  bit         idle_on      = 1'b1;
  bit         send_gaps_on = 1'b1;
  bit         hold_req     = 1'b0;
  int         n_settings;

  magnet_code_bin_selector #(
    .TIMER_WIDTH(TimerW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // At least a quarter of the draws are zero so that back-to-back beats stay common.
  function automatic int draw_wait();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_item(input bit act, input bit sa, input bit sb_lvl, input bit home);
    int gap;
    gap = send_gaps_on ? draw_wait() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, home, sb_lvl, sa};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_tick(act, sa, sb_lvl, home);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_setting(input setting_t s);
    cfg_reg_e  r;
    cfg_data_t v;
    r = r.first();
    do begin
      case (r)
        REG_DEBOUNCE:  v = s.debounce;
        REG_WINDOW:    v = s.window;
        REG_BIN_ONE:   v = s.bin_word[0];
        REG_BIN_TWO:   v = s.bin_word[1];
        REG_BIN_THREE: v = s.bin_word[2];
        default:       v = s.bin_word[3];
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= v;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      board.set_reg(r, v);
      r = r.next();
    end while (r != r.first());
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // One well-formed item: start, debounce pulses on either sensor, the feeder
  // switch, then a tail of ticks that may run past the end of the window.
  task automatic run_item();
    int dl, wl, pulses, len;
    bit on_a, on_b;
    dl = (board.debounce > 120) ? 8 : int'(board.debounce);
    wl = (board.window > 80) ? 12 : int'(board.window);
    send_item(1'b1, rbit(), rbit(), rbit());
    pulses = $urandom_range(0, 5);
    repeat (pulses) begin
      on_a = rbit();
      on_b = rbit();
      len  = rbit() ? dl + $urandom_range(0, 2) : $urandom_range(0, dl + 2);
      repeat (len) send_item(1'b0, on_a, on_b, 1'b0);
      len  = rbit() ? dl + $urandom_range(0, 2) : $urandom_range(0, dl + 2);
      repeat (len) send_item(1'b0, 1'b0, 1'b0, 1'b0);
    end
    send_item(1'b0, rbit(), rbit(), 1'b1);
    len = $urandom_range(0, wl + 4);
    repeat (len) send_item(1'b0, rbit(), rbit(), rbit());
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) send_item($urandom_range(0, 7) == 0, rbit(), rbit(), rbit());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready) begin
      board.check_tally(m_axis_tlast, m_axis_tdata[3:0], m_axis_tdata[5:4], m_axis_tdata[6]);
    end
  end

  // Output side: random stalls per beat, plus one long hold-off on request.
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        stall = draw_wait();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    #(20ms);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    setting_t cfg;
    int       ph;
    int       phase_end;
    int       waited;
    board = new();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_DEBOUNCE;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero debounce, a short window; counts three and four share a bin.
    cfg.debounce    = '0;
    cfg.window      = 16'd3;
    cfg.bin_word[0] = 16'd1;
    cfg.bin_word[1] = 16'd2;
    cfg.bin_word[2] = 16'd3;
    cfg.bin_word[3] = 16'd3;
    load_setting(cfg);
    send_item(1'b1, 1'b1, 1'b1, 1'b1);    // start ignores the levels
    send_item(1'b0, 1'b1, 1'b1, 1'b0);    // both sensors count on one tick
    send_item(1'b0, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 1'b1, 1'b0, 1'b1);    // feeder switch opens phase two
    send_item(1'b0, 1'b0, 1'b0, 1'b0);    // window closes
    send_item(1'b0, 1'b1, 1'b1, 1'b1);    // finished item holds its result
    send_item(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (8) begin
      send_item(1'b0, 1'b1, 1'b1, 1'b0);  // drives the count into saturation
      send_item(1'b0, 1'b0, 1'b0, 1'b0);
    end
    send_item(1'b0, 1'b0, 1'b0, 1'b1);
    send_item(1'b0, 1'b0, 1'b0, 1'b0);    // count past the limit maps to no bin

    // The first four phases always run, so the receiver hold-off is never skipped.
    ph = 0;
    while (ph < 4 || board.n_in < RandomBeats) begin
      idle_input();
      wait_drained();
      foreach (cfg.bin_word[i]) cfg.bin_word[i] = cfg_data_t'($urandom_range(0, 65535));
      case (ph)
        0: begin
          cfg.debounce = DebounceReset;
          cfg.window   = WindowReset;
          foreach (cfg.bin_word[i]) cfg.bin_word[i] = '0;
        end
        1: begin
          cfg.debounce = '0;
          cfg.window   = '0;
          foreach (cfg.bin_word[i]) cfg.bin_word[i] = '1;
        end
        2: begin
          cfg.debounce = '1;
          cfg.window   = cfg_data_t'($urandom_range(0, 20));
        end
        default: begin
          cfg.debounce = cfg_data_t'($urandom_range(0, 5));
          cfg.window   = cfg_data_t'($urandom_range(0, 24));
        end
      endcase
      load_setting(cfg);
      idle_on = (ph % 4 != 1);
      if (ph == 3) begin
        // Hold the output off while beats keep coming, so the input stalls.
        send_gaps_on = 1'b0;
        hold_req     = 1'b1;
        phase_end    = board.n_in + 60;
        while (board.n_in < phase_end) run_item();
        send_gaps_on = 1'b1;
      end
      phase_end = board.n_in + ((ph == 0) ? 450 : 150);
      while (board.n_in < phase_end) begin
        if ($urandom_range(0, 99) < 15) noise_burst();
        else run_item();
      end
      ph++;
    end

    // Long run: a latched sensor stays high, so its hold counter keeps climbing
    // while the window stays open.
    idle_input();
    wait_drained();
    idle_on      = 1'b0;
    cfg.debounce = 16'd2;
    cfg.window   = '1;
    foreach (cfg.bin_word[i]) cfg.bin_word[i] = cfg_data_t'($urandom_range(0, 65535));
    load_setting(cfg);
    send_item(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (SatTicks) send_item(1'b0, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, 1'b0, 1'b0, 1'b0);
    repeat (2) send_item(1'b0, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, 1'b0, 1'b0, 1'b1);
    send_item(1'b0, 1'b0, 1'b0, 1'b0);
    idle_input();

    waited = 0;
    while (board.pending() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.errors++;
    end

    $display("testbench: %0d tick beats under %0d register settings, %0d results checked",
             board.n_in, n_settings, board.n_out);
    $display("testbench: %0d items closed by window or magnet limit, %0d mismatches",
             board.n_closed, board.errors);
    if (board.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* magnet_code_bin_selector.f */
rtl/core/mcbs_pkg.sv
rtl/core/magnet_code_bin_selector.sv
sim/testbench.sv
